// File: rtl/slpc_pkg.sv
package slpc_pkg;

  // Field widths of the item channels
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ModeW     = 3;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned DurW      = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 3;

  // Pulse phase quantization: 64 steps, one quotient bit per divider step
  localparam int unsigned PhaseBits = 6;
  localparam int unsigned DivSteps  = TimeW + PhaseBits;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

  // Colors, packed 0xRRGGBB
  localparam logic [ColorW-1:0] ColOff    = 24'h000000;
  localparam logic [ColorW-1:0] ColGreen  = 24'h00FF00;
  localparam logic [ColorW-1:0] ColRed    = 24'hFF0000;
  localparam logic [ColorW-1:0] ColYellow = 24'hFFFF00;
  localparam logic [ColorW-1:0] ColBlue   = 24'h0000FF;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPulsePeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdleBlink   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBlinkOn     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLowBatt     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCritToggle  = 3'd4;

  // Configuration reset values
  localparam logic [CfgW-1:0] RstPulsePeriod = 16'd2000;
  localparam logic [CfgW-1:0] RstIdleBlink   = 16'd3000;
  localparam logic [CfgW-1:0] RstBlinkOn     = 16'd100;
  localparam logic [CfgW-1:0] RstLowBatt     = 16'd1000;
  localparam logic [CfgW-1:0] RstCritToggle  = 16'd250;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET_MODE = 2'd1,
    CMD_FLASH    = 2'd2
  } cmd_e;

  typedef enum logic [ModeW-1:0] {
    MODE_OFF      = 3'd0,
    MODE_PULSE    = 3'd1,
    MODE_IDLE     = 3'd2,
    MODE_TALK     = 3'd3,
    MODE_LOW_BATT = 3'd4,
    MODE_CRITICAL = 3'd5,
    MODE_BLUE     = 3'd6,
    MODE_RED      = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_LEVEL,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ModeW-1:0]  new_mode;
    logic [ColorW-1:0] flash_color;
    logic [DurW-1:0]   flash_duration_ms;
  } in_item_t;

  typedef struct packed {
    logic [ColorW-1:0] pixel_color;
    logic              builtin_led_on;
    logic              flash_showing;
    logic [ModeW-1:0]  current_mode;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic exec;
    logic div_step;
    logic level_wr;
    logic out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_sts_t;

  // Breathing brightness for phase step k: 32 plus or minus a sine approximation
  // q = 120*m/(1280-m), m = j*(32-j), j = k mod 32; floor on the rising half,
  // ceil on the falling half.
  function automatic logic [PhaseBits-1:0] pulse_level(input logic [PhaseBits-1:0] k);
    logic [4:0] j;
    logic [4:0] qf;
    logic       inexact;
    j = k[4:0];
    case (j)
      5'd0:  qf = 5'd0;
      5'd1:  qf = 5'd2;
      5'd2:  qf = 5'd5;
      5'd3:  qf = 5'd8;
      5'd4:  qf = 5'd11;
      5'd5:  qf = 5'd14;
      5'd6:  qf = 5'd16;
      5'd7:  qf = 5'd19;
      5'd8:  qf = 5'd21;
      5'd9:  qf = 5'd23;
      5'd10: qf = 5'd24;
      5'd11: qf = 5'd26;
      5'd12: qf = 5'd27;
      5'd13: qf = 5'd28;
      5'd14: qf = 5'd29;
      5'd15: qf = 5'd29;
      5'd16: qf = 5'd30;
      5'd17: qf = 5'd29;
      5'd18: qf = 5'd29;
      5'd19: qf = 5'd28;
      5'd20: qf = 5'd27;
      5'd21: qf = 5'd26;
      5'd22: qf = 5'd24;
      5'd23: qf = 5'd23;
      5'd24: qf = 5'd21;
      5'd25: qf = 5'd19;
      5'd26: qf = 5'd16;
      5'd27: qf = 5'd14;
      5'd28: qf = 5'd11;
      5'd29: qf = 5'd8;
      5'd30: qf = 5'd5;
      default: qf = 5'd2;
    endcase
    // only the zero and peak phases divide evenly
    inexact = (j != 5'd0) && (j != 5'd16);
    if (!k[PhaseBits-1]) begin
      pulse_level = 6'd32 + {1'b0, qf};
    end else begin
      pulse_level = 6'd32 - {1'b0, qf} - {5'd0, inexact};
    end
  endfunction

endpackage

// File: rtl/slpc_div.sv
module slpc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           step_i,
  input  logic [slpc_pkg::TimeW-1:0]     dividend_i,
  input  logic [slpc_pkg::CfgW-1:0]      divisor_i,
  output logic [slpc_pkg::PhaseBits-1:0] phase_o,
  output logic                           last_o
);
  import slpc_pkg::*;

  logic [TimeW-1:0]     dvd_q, dvd_d;
  logic [CfgW-1:0]      rem_q, rem_d;
  logic [PhaseBits-1:0] quo_q, quo_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [CfgW:0]        trial;
  logic                 fits;

  // One restoring step: 32 steps give the remainder mod period, then
  // the next steps shift in zeros and yield the phase quotient bits.
  always_comb begin
    trial = {rem_q, dvd_q[TimeW-1]};
    fits  = trial >= {1'b0, divisor_i};
    dvd_d = dvd_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (step_i) begin
      dvd_d = {dvd_q[TimeW-2:0], 1'b0};
      rem_d = fits ? CfgW'(trial - {1'b0, divisor_i}) : trial[CfgW-1:0];
      quo_d = {quo_q[PhaseBits-2:0], fits};
      cnt_d = cnt_q + DivCntW'(1);
    end
  end

  // Hold the step count under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign phase_o = quo_q;
  assign last_o  = cnt_q == DivCntW'(DivSteps - 1);

endmodule

// File: rtl/slpc_dp.sv
module slpc_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  slpc_pkg::in_item_t         in_item_i,
  output slpc_pkg::out_item_t        out_item_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  input  logic                       cfg_we_i,
  input  logic [slpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slpc_pkg::CfgW-1:0]  cfg_wdata_i,
  input  slpc_pkg::ctrl_cmd_t        cmd_i,
  output slpc_pkg::dp_sts_t          sts_o
);
  import slpc_pkg::*;

  // Configuration registers
  logic [CfgW-1:0] pulse_per_q, idle_int_q, blink_on_q, low_int_q, crit_q;

  // Pattern state
  logic [TimeW-1:0]  time_q, time_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  toggle_q, toggle_d;
  logic [TimeW-1:0]  flash_end_q, flash_end_d;
  mode_e             mode_q, mode_d;
  mode_e             prev_q, prev_d;
  logic              blink_q, blink_d;
  logic              flash_q, flash_d;
  logic              builtin_q, builtin_d;
  logic [ColorW-1:0] pixel_q, pixel_d;

  // Item and result registers
  in_item_t  item_q;
  out_item_t out_q;
  logic      out_valid_q, out_valid_d;

  // Tick helpers
  logic [TimeW-1:0]     time_inc, start_eff, since_toggle;
  logic                 flash_exp, run_pat;
  mode_e                mode_eff, mode_new;
  logic [CfgW-1:0]      hb_int, div_per;
  logic [ColorW-1:0]    hb_col;
  logic [PhaseBits-1:0] phase;
  logic                 div_last;

  assign mode_new     = mode_e'(item_q.new_mode);
  assign time_inc     = time_q + TimeW'(1);
  assign flash_exp    = time_inc >= flash_end_q;
  assign run_pat      = !flash_q || flash_exp;
  assign mode_eff     = flash_q ? prev_q : mode_q;
  assign start_eff    = flash_q ? time_inc : start_q;
  assign since_toggle = time_inc - toggle_q;
  assign hb_int       = (mode_eff == MODE_IDLE) ? idle_int_q : low_int_q;
  assign hb_col       = (mode_eff == MODE_IDLE) ? ColGreen : ColYellow;
  assign div_per      = (pulse_per_q == '0) ? CfgW'(1) : pulse_per_q;

  assign sts_o.need_div = (cmd_e'(item_q.cmd) == CMD_TICK) && run_pat &&
                          (mode_eff == MODE_PULSE);
  assign sts_o.div_last = div_last;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  slpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.exec && sts_o.need_div),
    .step_i     (cmd_i.div_step),
    .dividend_i (time_inc - start_eff),
    .divisor_i  (div_per),
    .phase_o    (phase),
    .last_o     (div_last)
  );

  // Apply the held item to the pattern state
  always_comb begin
    time_d      = time_q;
    start_d     = start_q;
    toggle_d    = toggle_q;
    flash_end_d = flash_end_q;
    mode_d      = mode_q;
    prev_d      = prev_q;
    blink_d     = blink_q;
    flash_d     = flash_q;
    builtin_d   = builtin_q;
    pixel_d     = pixel_q;
    if (cmd_i.exec) begin
      case (cmd_e'(item_q.cmd))
        CMD_TICK: begin
          time_d = time_inc;
          // end an expired flash and restore the saved mode
          if (flash_q && flash_exp) begin
            flash_d = 1'b0;
            mode_d  = prev_q;
            start_d = time_inc;
          end
          if (run_pat) begin
            case (mode_eff) inside
              MODE_OFF: pixel_d = ColOff;
              MODE_PULSE: ;
              MODE_IDLE, MODE_LOW_BATT: begin
                if (since_toggle >= {{(TimeW-CfgW){1'b0}}, hb_int}) begin
                  pixel_d  = hb_col;
                  toggle_d = time_inc;
                  blink_d  = 1'b1;
                end else if (blink_q &&
                             since_toggle >= {{(TimeW-CfgW){1'b0}}, blink_on_q}) begin
                  pixel_d = ColOff;
                  blink_d = 1'b0;
                end
              end
              MODE_TALK: begin
                pixel_d   = ColRed;
                builtin_d = 1'b1;
              end
              MODE_CRITICAL: begin
                if (since_toggle >= {{(TimeW-CfgW){1'b0}}, crit_q}) begin
                  blink_d  = !blink_q;
                  pixel_d  = blink_q ? ColOff : ColRed;
                  toggle_d = time_inc;
                end
              end
              MODE_BLUE: pixel_d = ColBlue;
              default:   pixel_d = ColRed;
            endcase
          end
        end
        CMD_SET_MODE: begin
          if (!(mode_new == mode_q && !flash_q)) begin
            prev_d   = mode_q;
            mode_d   = mode_new;
            start_d  = time_q;
            toggle_d = '0;
            blink_d  = 1'b0;
            if (mode_q == MODE_TALK && mode_new != MODE_TALK) begin
              builtin_d = 1'b0;
            end
          end
        end
        CMD_FLASH: begin
          prev_d      = mode_q;
          flash_d     = 1'b1;
          flash_end_d = time_q + {{(TimeW-DurW){1'b0}}, item_q.flash_duration_ms};
          pixel_d     = item_q.flash_color;
        end
        default: ;
      endcase
    end
    // write the breathing level once the phase is known
    if (cmd_i.level_wr) begin
      pixel_d = {{(ColorW-PhaseBits){1'b0}}, pulse_level(phase)};
    end
  end

  // Mark the result register full on load, empty when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State, configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_per_q <= RstPulsePeriod;
      idle_int_q  <= RstIdleBlink;
      blink_on_q  <= RstBlinkOn;
      low_int_q   <= RstLowBatt;
      crit_q      <= RstCritToggle;
      time_q      <= '0;
      start_q     <= '0;
      toggle_q    <= '0;
      flash_end_q <= '0;
      mode_q      <= MODE_OFF;
      prev_q      <= MODE_OFF;
      blink_q     <= 1'b0;
      flash_q     <= 1'b0;
      builtin_q   <= 1'b0;
      pixel_q     <= ColOff;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgPulsePeriod: pulse_per_q <= cfg_wdata_i;
          CfgIdleBlink:   idle_int_q  <= cfg_wdata_i;
          CfgBlinkOn:     blink_on_q  <= cfg_wdata_i;
          CfgLowBatt:     low_int_q   <= cfg_wdata_i;
          CfgCritToggle:  crit_q      <= cfg_wdata_i;
          default: ;
        endcase
      end
      time_q      <= time_d;
      start_q     <= start_d;
      toggle_q    <= toggle_d;
      flash_end_q <= flash_end_d;
      mode_q      <= mode_d;
      prev_q      <= prev_d;
      blink_q     <= blink_d;
      flash_q     <= flash_d;
      builtin_q   <= builtin_d;
      pixel_q     <= pixel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      item_q <= in_item_i;
    end
    if (cmd_i.out_load) begin
      out_q.pixel_color    <= pixel_q;
      out_q.builtin_led_on <= builtin_q;
      out_q.flash_showing  <= flash_q;
      out_q.current_mode   <= mode_q;
    end
  end

  assign out_item_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/slpc_ctrl.sv
module slpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slpc_pkg::dp_sts_t    sts_i,
  output slpc_pkg::ctrl_cmd_t  cmd_o
);
  import slpc_pkg::*;

  ctrl_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC:  state_d = sts_i.need_div ? ST_DIV : ST_DONE;
      ST_DIV:   if (sts_i.div_last) state_d = ST_LEVEL;
      ST_LEVEL: state_d = ST_DONE;
      ST_DONE:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.cap  = in_valid_i;
      end
      ST_EXEC:  cmd_o.exec     = 1'b1;
      ST_DIV:   cmd_o.div_step = 1'b1;
      ST_LEVEL: cmd_o.level_wr = 1'b1;
      ST_DONE:  cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/status_led_pattern_controller_unit.sv
// Sequence: an accepted item is executed and its result loaded into the result
// register; a tick in pulse mode first runs the 38-step restoring divider and
// writes the breathing level. A new item is taken only after the last result is
// loaded, which waits while the result register is full and the output stalled.
// Reset (rst_ni low, asynchronous): clock, modes, timers and LED state clear,
// configuration registers return to their defaults, no result is pending.
module status_led_pattern_controller_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  slpc_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output slpc_pkg::out_item_t          out_item_o,
  input  logic                         cfg_we_i,
  input  logic [slpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slpc_pkg::CfgW-1:0]    cfg_wdata_i
);
  import slpc_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;

  slpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd)
  );

  slpc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_item_o  (out_item_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts)
  );

endmodule
